// ----- rtl/core/hsa_pkg.sv -----
// Shared types and constants for the ascending sort unit.
package hsa_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned DataWidth    = 32;

  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    logic                        last;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] sorted_value;
    logic                        final_res;
    logic                        overflow;
  } out_item_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/hsa_cell.sv -----
// One cell of the sorting chain: holds one value, inserts in order, shifts towards the head.
module hsa_cell (
  input  logic                                clk_i,
  input  hsa_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                occupied_i,
  input  logic signed [hsa_pkg::DataWidth-1:0] new_value_i,
  input  logic signed [hsa_pkg::DataWidth-1:0] prev_value_i,
  input  logic                                prev_keep_i,
  input  logic signed [hsa_pkg::DataWidth-1:0] next_value_i,
  output logic signed [hsa_pkg::DataWidth-1:0] value_o,
  output logic                                keep_o
);

  logic signed [hsa_pkg::DataWidth-1:0] value_q;
  logic signed [hsa_pkg::DataWidth-1:0] value_d;

  assign keep_o  = occupied_i && !(new_value_i < value_q);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.insert) begin
      if (keep_o) begin
        value_d = value_q;
      end else if (prev_keep_i) begin
        value_d = new_value_i;
      end else begin
        value_d = prev_value_i;
      end
    end else if (ctrl_i.shift) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ----- rtl/core/heap_sort_ascending_unit.sv -----
// Top level of the ascending sort unit: chain of sorting cells and load/drain control.
//
//   channel | handshake                  | payload
//   --------+----------------------------+--------------------------------------
//   in      | in_valid_i / in_stall_o    | in_item_i  (value, last)
//   out     | out_valid_o / out_stall_i  | out_item_o (sorted_value, final_res, overflow)
//
// Loading takes one item per cycle; each cell compares the new value with its own and the
// chain inserts it in order in the same cycle.
// After the item marked last, results follow one per cycle from the head cell while the out
// channel does not stall; the input stalls while results drain.
// Reset empties the chain at once; an out stall holds the head result and the chain.
module heap_sort_ascending_unit #(
  parameter int unsigned DEPTH = hsa_pkg::DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hsa_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hsa_pkg::out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     count_q;
  logic                dropped_q;

  logic                in_acc;
  logic                out_acc;
  logic                full;
  hsa_pkg::cell_ctrl_t ctrl;

  logic signed [hsa_pkg::DataWidth-1:0] cell_value [DEPTH];
  logic                                 cell_keep  [DEPTH];

  assign in_stall_o  = (state_q == ST_DRAIN);
  assign out_valid_o = (state_q == ST_DRAIN);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign full        = (count_q == CntW'(DEPTH));
  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  assign out_item_o.sorted_value = cell_value[0];
  assign out_item_o.final_res    = (count_q == CntW'(1));
  assign out_item_o.overflow     = dropped_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [hsa_pkg::DataWidth-1:0] prev_value;
    logic                                 prev_keep;
    logic signed [hsa_pkg::DataWidth-1:0] next_value;

    if (i == 0) begin : g_head
      assign prev_value = in_item_i.value;
      assign prev_keep  = 1'b0;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_keep  = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_value = cell_value[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
    end

    hsa_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (CntW'(i) < count_q),
      .new_value_i  (in_item_i.value),
      .prev_value_i (prev_value),
      .prev_keep_i  (prev_keep),
      .next_value_i (next_value),
      .value_o      (cell_value[i]),
      .keep_o       (cell_keep[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (ctrl.insert) begin
            count_q <= count_q + CntW'(1);
          end
          if (in_acc && full) begin
            dropped_q <= 1'b1;
          end
          if (in_acc && in_item_i.last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_acc) begin
            count_q <= count_q - CntW'(1);
            if (count_q == CntW'(1)) begin
              state_q   <= ST_LOAD;
              dropped_q <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  a_drain_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (count_q != '0))
    else $error("draining with an empty chain");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count beyond depth");

  a_last_starts_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.last) |=> out_valid_o)
    else $error("last item did not start the drain");

  a_final_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_item_o.final_res) |=> (state_q == ST_LOAD && count_q == '0 && !dropped_q))
    else $error("run not cleared after final result");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench of the ascending sort unit: a directed table and random runs, checked against a predictor.
module tb;

  localparam int unsigned StoreDepth  = hsa_pkg::DefaultDepth;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned CycleLimit  = 200000;

  typedef logic signed [hsa_pkg::DataWidth-1:0] elem_t;

  typedef struct packed {
    hsa_pkg::in_item_t  item;
    logic               has_result;
    hsa_pkg::out_item_t result;
  } directed_row_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  hsa_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  hsa_pkg::out_item_t out_item_o;

  elem_t              held_elems[$];
  logic               elems_dropped = 1'b0;
  hsa_pkg::out_item_t pending_sorted[$];
  hsa_pkg::out_item_t oldest_sorted;
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        hold_left   = 0;
  logic               calm         = 1'b0;
  logic               hold_request = 1'b0;
  logic               hold_done    = 1'b0;

  heap_sort_ascending_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CycleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic directed_row_t plain(elem_t value, logic last);
    directed_row_t row;
    row = '0;
    row.item.value = value;
    row.item.last  = last;
    return row;
  endfunction

  // single-element run: the result is the element itself, marked final
  function automatic directed_row_t known(elem_t value);
    directed_row_t row;
    row = plain(value, 1'b1);
    row.has_result          = 1'b1;
    row.result.sorted_value = value;
    row.result.final_res    = 1'b1;
    row.result.overflow     = 1'b0;
    return row;
  endfunction

  function automatic void predict_sorted_run(hsa_pkg::in_item_t item, logic has_result,
                                             hsa_pkg::out_item_t result);
    elem_t              ordered[$];
    hsa_pkg::out_item_t res;
    int unsigned        k;
    if (held_elems.size() < StoreDepth) begin
      held_elems.push_back(item.value);
    end else begin
      elems_dropped = 1'b1;
    end
    if (!item.last) return;
    if (has_result) begin
      pending_sorted.push_back(result);
    end else begin
      foreach (held_elems[i]) begin
        k = 0;
        while (k < ordered.size() && ordered[k] <= held_elems[i]) k++;
        ordered.insert(k, held_elems[i]);
      end
      foreach (ordered[i]) begin
        res.sorted_value = ordered[i];
        res.final_res    = (i == ordered.size() - 1);
        res.overflow     = elems_dropped;
        pending_sorted.push_back(res);
      end
    end
    held_elems.delete();
    elems_dropped = 1'b0;
  endfunction

  task automatic offer_item(hsa_pkg::in_item_t item);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_item_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sorted.size() == 0) begin
        $error("unexpected result: sorted_value %0d", out_item_o.sorted_value);
        error_count++;
      end else begin
        oldest_sorted = pending_sorted.pop_front();
        if (out_item_o.sorted_value !== oldest_sorted.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d",
                 oldest_sorted.sorted_value, out_item_o.sorted_value);
          error_count++;
        end
        if (out_item_o.final_res !== oldest_sorted.final_res) begin
          $error("final_res: expected %0b, got %0b",
                 oldest_sorted.final_res, out_item_o.final_res);
          error_count++;
        end
        if (out_item_o.overflow !== oldest_sorted.overflow) begin
          $error("overflow: expected %0b, got %0b",
                 oldest_sorted.overflow, out_item_o.overflow);
          error_count++;
        end
      end
    end
    if (hold_request && !hold_done) begin
      hold_left   <= HoldCycles;
      hold_done   <= 1'b1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 25);
    end
  end

  initial begin
    directed_row_t     directed_rows[22];
    hsa_pkg::in_item_t item;
    int unsigned       sent;
    int unsigned       run_idx;
    int unsigned       run_len;
    int unsigned       pick;
    directed_rows = '{
      known(32'sh7fffffff), known(32'sh80000000), known(32'sh0), known(-32'sh1),
      plain(32'sh5, 1'b0), plain(32'sh80000000, 1'b0), plain(32'sh7fffffff, 1'b0),
      plain(-32'sh1, 1'b0), plain(32'sh0, 1'b0), plain(32'sh1, 1'b1),
      plain(32'sh7, 1'b0), plain(32'sh7, 1'b0), plain(-32'sh3, 1'b0), plain(32'sh7, 1'b1),
      plain(32'sh55555555, 1'b0), plain(32'shaaaaaaaa, 1'b0), plain(32'sh3, 1'b0),
      plain(32'sh2, 1'b0), plain(32'sh1, 1'b1),
      plain(-32'sh2, 1'b0), plain(-32'sh1, 1'b0), plain(32'sh0, 1'b1)
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].item);
      predict_sorted_run(directed_rows[i].item, directed_rows[i].has_result,
                         directed_rows[i].result);
    end

    sent    = 0;
    run_idx = 0;
    while (sent < RandomItems) begin
      if (run_idx == 0) begin
        run_len      = StoreDepth;
        hold_request = 1'b1;
      end else if (run_idx == 1) begin
        run_len = StoreDepth + 1;
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) run_len = $urandom_range(8, 1);
        else if (pick < 85) run_len = $urandom_range(40, 9);
        else if (pick < 93) run_len = $urandom_range(StoreDepth, 41);
        else run_len = $urandom_range(StoreDepth + 8, StoreDepth);
      end
      calm = (sent >= 150 && sent < 250);
      for (int unsigned k = 0; k < run_len; k++) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          case ($urandom_range(3))
            0:       item.value = 32'sh80000000;
            1:       item.value = 32'sh7fffffff;
            2:       item.value = 32'sh0;
            default: item.value = -32'sh1;
          endcase
        end else if (pick < 40) begin
          item.value = $signed($urandom_range(8)) - 4;
        end else begin
          item.value = $urandom;
        end
        item.last = (k == run_len - 1);
        offer_item(item);
        predict_sorted_run(item, 1'b0, '0);
        sent++;
      end
      run_idx++;
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (pending_sorted.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/hsa_pkg.sv
rtl/core/hsa_cell.sv
rtl/core/heap_sort_ascending_unit.sv
verif/tb.sv
